// ----- rtl/tclu_pkg.sv -----
// Package for the typed compare and logic unit: operation, type and fault codes,
// the field widths and the int-to-single conversion function.
// Depends on nothing.
package tclu_pkg;

  localparam int OpW    = 4;
  localparam int TypeW  = 2;
  localparam int ValW   = 32;
  localparam int FaultW = 2;
  localparam int InDataW  = 72;  // 4+2+32+2+32 = 72, already whole bytes
  localparam int OutDataW = 8;

  typedef enum logic [OpW-1:0] {
    OP_EQL  = 4'd0,
    OP_NEQL = 4'd1,
    OP_GT   = 4'd2,
    OP_GTE  = 4'd3,
    OP_LT   = 4'd4,
    OP_LTE  = 4'd5,
    OP_LAND = 4'd6,
    OP_LOR  = 4'd7,
    OP_LNOT = 4'd8
  } op_t;

  typedef enum logic [TypeW-1:0] {
    TY_NIL     = 2'd0,
    TY_INT     = 2'd1,
    TY_FLOAT   = 2'd2,
    TY_CLOSURE = 2'd3
  } ty_t;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_NIL     = 2'd1,
    FAULT_CLOSURE = 2'd2
  } fault_t;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [TypeW-1:0] top_type;
    logic [ValW-1:0]  top_value;
    logic [TypeW-1:0] second_type;
    logic [ValW-1:0]  second_value;
  } item_t;

  typedef struct packed {
    logic              truth;
    logic [FaultW-1:0] fault;
  } result_t;

  // Signed 32-bit integer to IEEE single, round to nearest even.
  function automatic logic [31:0] int_to_single(input logic [31:0] v);
    logic        s;
    logic [31:0] mag;
    logic [31:0] norm;
    logic [4:0]  lz;
    logic        found;
    logic [23:0] mant;
    logic        g;
    logic        st;
    logic [24:0] rnd;
    logic [7:0]  ex;
    s = v[31];
    mag = s ? (~v + 32'd1) : v;
    lz = 5'd0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && mag[i]) begin
        found = 1'b1;
        lz = 5'(31 - i);
      end
    end
    norm = mag << lz;
    mant = norm[31:8];
    g = norm[7];
    st = |norm[6:0];
    rnd = {1'b0, mant} + 25'(g & (st | mant[0]));
    ex = 8'(8'd158 - {3'd0, lz});
    if (rnd[24]) begin
      ex = ex + 8'd1;
    end
    if (!found) begin
      int_to_single = 32'd0;
    end else begin
      int_to_single = {s, ex, rnd[24] ? 23'd0 : rnd[22:0]};
    end
  endfunction

endpackage

// ----- rtl/tclu_core.sv -----
// Combinational evaluation of one request: nil policy, closure check,
// integer or IEEE single compare and truthiness logic. Uses tclu_pkg.
module tclu_core (
  input  tclu_pkg::item_t   item,
  output tclu_pkg::result_t res
);
  import tclu_pkg::*;

  logic        an, bn, both_int;
  logic [31:0] fa, fb;
  logic        a_nan, b_nan, unord, a_zero, b_zero;
  logic        f_lt, f_eq, i_lt, i_eq, lt, eq, gt;
  logic        ta_true, tb_true;

  assign an = item.top_type == TY_NIL;
  assign bn = item.second_type == TY_NIL;
  assign both_int = item.top_type == TY_INT && item.second_type == TY_INT;

  assign fa = (item.top_type == TY_FLOAT) ? item.top_value : int_to_single(item.top_value);
  assign fb = (item.second_type == TY_FLOAT) ? item.second_value
                                             : int_to_single(item.second_value);

  assign a_nan = &fa[30:23] && |fa[22:0];
  assign b_nan = &fb[30:23] && |fb[22:0];
  assign unord = a_nan | b_nan;
  assign a_zero = fa[30:0] == 31'd0;
  assign b_zero = fb[30:0] == 31'd0;

  // Sign-magnitude ordering; both zeros compare equal.
  always_comb begin
    f_eq = (fa == fb) || (a_zero && b_zero);
    if (fa[31] != fb[31]) begin
      f_lt = fa[31] && !(a_zero && b_zero);
    end else if (fa[31]) begin
      f_lt = fa[30:0] > fb[30:0];
    end else begin
      f_lt = fa[30:0] < fb[30:0];
    end
  end

  assign i_lt = $signed(item.top_value) < $signed(item.second_value);
  assign i_eq = item.top_value == item.second_value;

  assign lt = both_int ? i_lt : (!unord && f_lt);
  assign eq = both_int ? i_eq : (!unord && f_eq);
  assign gt = both_int ? (!i_lt && !i_eq) : (!unord && !f_lt && !f_eq);

  // Truthiness: an int is true when non-zero, a float when not +-0.
  assign ta_true = (item.top_type == TY_CLOSURE)
                || (item.top_type == TY_INT && item.top_value != 32'd0)
                || (item.top_type == TY_FLOAT && item.top_value[30:0] != 31'd0);
  assign tb_true = (item.second_type == TY_CLOSURE)
                || (item.second_type == TY_INT && item.second_value != 32'd0)
                || (item.second_type == TY_FLOAT && item.second_value[30:0] != 31'd0);

  always_comb begin
    res.truth = 1'b0;
    res.fault = FAULT_NONE;
    case (item.operation)
      OP_EQL, OP_NEQL, OP_GT, OP_GTE, OP_LT, OP_LTE: begin
        if (an != bn) begin
          if (item.operation == OP_NEQL) begin
            res.truth = 1'b1;
          end else if (item.operation != OP_EQL) begin
            res.fault = FAULT_NIL;
          end
        end else if (an) begin
          res.truth = item.operation == OP_EQL || item.operation == OP_GTE
                   || item.operation == OP_LTE;
        end else if (item.top_type == TY_CLOSURE || item.second_type == TY_CLOSURE) begin
          res.fault = FAULT_CLOSURE;
        end else begin
          case (item.operation)
            OP_EQL:  res.truth = eq;
            OP_NEQL: res.truth = !eq;
            OP_GT:   res.truth = gt;
            OP_GTE:  res.truth = gt | eq;
            OP_LT:   res.truth = lt;
            default: res.truth = lt | eq;
          endcase
        end
      end
      OP_LAND: res.truth = ta_true & tb_true;
      OP_LOR:  res.truth = ta_true | tb_true;
      OP_LNOT: res.truth = !ta_true;
      default: res.truth = 1'b0;
    endcase
  end

endmodule

// ----- rtl/typed_compare_logic_unit_top.sv -----
// Top level of the typed compare and logic unit: input register, evaluation
// logic (tclu_core) and an output register. Uses tclu_pkg.
//
// The unit takes one request per cycle when the output side is not stalled and
// returns exactly one result per request, through the input and then the output register.
// A request is latched into an input register, evaluated by a single pass of
// combinational logic (nil policy, closure check, int-to-single conversion and
// the integer or IEEE compare, or truthiness for LAND, LOR and LNOT) and the
// answer is captured in an output register. The sustained rate is one request
// per cycle while results are taken, set by that single evaluation stage; both
// registers advance together when the output is free or being taken, so back
// pressure on the result side holds the pipe without losing anything.
module typed_compare_logic_unit_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // operation[3:0], top_type[5:4], top_value[37:6], second_type[39:38],
  // second_value[71:40]
  input  logic [tclu_pkg::InDataW-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // truth[0], fault[2:1], zero fill up to bit 7
  output logic [tclu_pkg::OutDataW-1:0] m_tdata
);
  import tclu_pkg::*;

  logic    in_valid;
  item_t   in_item;
  result_t core_res;
  result_t out_res;
  logic    adv;

  // The pipe moves whenever the result register is empty or being drained.
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_tvalid;
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_item.operation    <= s_tdata[3:0];
      in_item.top_type     <= s_tdata[5:4];
      in_item.top_value    <= s_tdata[37:6];
      in_item.second_type  <= s_tdata[39:38];
      in_item.second_value <= s_tdata[71:40];
      out_res <= core_res;
    end
  end

  tclu_core u_core (
    .item(in_item),
    .res (core_res)
  );

  assign m_tdata = {5'd0, out_res.fault, out_res.truth};

  a_fault_clears_truth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:1] != 2'd0) |-> !m_tdata[0]) else $error("truth with fault");
  a_no_fault_code3: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:1] != 2'd3) else $error("bad fault code");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(out_res)) else $error("result lost");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && adv |=> m_tvalid) else $error("item dropped");

endmodule

// ----- tb/typed_compare_logic_unit_top_tb.sv -----
// Testbench for typed_compare_logic_unit_top. It sends requests over the input stream
// and checks each result against a predictor kept in the testbench.
// Depends on tclu_pkg and typed_compare_logic_unit_top.
`timescale 1ns / 1ps

module typed_compare_logic_unit_top_tb;
  import tclu_pkg::*;

  // Outcome of an ordered comparison between two operands.
  localparam logic [1:0] REL_LESS = 2'd0, REL_EQUAL = 2'd1, REL_GREATER = 2'd2,
                         REL_UNORDERED = 2'd3;
  localparam int IdleLimit = 5000;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  result_t expected_results[$];
  int      failures;
  int      accepted_count;
  int      checked_count;
  int      idle_cycles;
  int      burst_left;

  typed_compare_logic_unit_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Signed integer to IEEE single, rounding to nearest with ties to even.
  function automatic logic [31:0] single_from_int(input logic [31:0] v);
    logic        sgn;
    logic [63:0] m;
    int          ex;
    logic        g;
    logic        sticky;
    sgn = v[31];
    m = sgn ? 64'(-$signed({1'b1, v})) : 64'(v);
    ex = 150;
    g = 1'b0;
    sticky = 1'b0;
    if (m == 0) return 32'd0;
    while (m < 64'h80_0000) begin
      m = m << 1;
      ex--;
    end
    while (m >= 64'h100_0000) begin
      sticky = sticky | g;
      g = m[0];
      m = m >> 1;
      ex++;
    end
    if (g && (sticky || m[0])) m = m + 1;
    if (m == 64'h100_0000) begin
      m = m >> 1;
      ex++;
    end
    return {sgn, 8'(ex), m[22:0]};
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return f[30:23] == 8'hff && f[22:0] != 0;
  endfunction

  // IEEE compare done on the bit patterns: signed zeros are equal, NaN is unordered.
  function automatic logic [1:0] float_relation(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if (is_nan(a) || is_nan(b)) return REL_UNORDERED;
    if (a[30:0] == 0 && b[30:0] == 0) return REL_EQUAL;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    if (ka < kb) return REL_LESS;
    if (ka == kb) return REL_EQUAL;
    return REL_GREATER;
  endfunction

  function automatic logic operand_truthy(input logic [1:0] ty, input logic [31:0] v);
    case (ty)
      TY_NIL:   return 1'b0;
      TY_INT:   return v != 0;
      TY_FLOAT: return v[30:0] != 0;
      default:  return 1'b1;
    endcase
  endfunction

  function automatic result_t predict_compare_logic(input item_t it);
    result_t     r;
    logic [1:0]  rel;
    logic [31:0] fa;
    logic [31:0] fb;
    logic        top_nil;
    logic        second_nil;
    r.truth = 1'b0;
    r.fault = FAULT_NONE;
    top_nil = it.top_type == TY_NIL;
    second_nil = it.second_type == TY_NIL;
    if (it.operation <= OP_LTE) begin
      if (top_nil != second_nil) begin
        if (it.operation == OP_NEQL) r.truth = 1'b1;
        else if (it.operation != OP_EQL) r.fault = FAULT_NIL;
      end else if (top_nil) begin
        r.truth = it.operation == OP_EQL || it.operation == OP_GTE || it.operation == OP_LTE;
      end else if (it.top_type == TY_CLOSURE || it.second_type == TY_CLOSURE) begin
        r.fault = FAULT_CLOSURE;
      end else begin
        if (it.top_type == TY_INT && it.second_type == TY_INT) begin
          if ($signed(it.top_value) < $signed(it.second_value)) rel = REL_LESS;
          else if (it.top_value == it.second_value) rel = REL_EQUAL;
          else rel = REL_GREATER;
        end else begin
          fa = it.top_type == TY_INT ? single_from_int(it.top_value) : it.top_value;
          fb = it.second_type == TY_INT ? single_from_int(it.second_value) : it.second_value;
          rel = float_relation(fa, fb);
        end
        case (it.operation)
          OP_EQL:  r.truth = rel == REL_EQUAL;
          OP_NEQL: r.truth = rel != REL_EQUAL;
          OP_GT:   r.truth = rel == REL_GREATER;
          OP_GTE:  r.truth = rel == REL_GREATER || rel == REL_EQUAL;
          OP_LT:   r.truth = rel == REL_LESS;
          default: r.truth = rel == REL_LESS || rel == REL_EQUAL;
        endcase
      end
    end else if (it.operation == OP_LAND) begin
      r.truth = operand_truthy(it.top_type, it.top_value) &&
                operand_truthy(it.second_type, it.second_value);
    end else if (it.operation == OP_LOR) begin
      r.truth = operand_truthy(it.top_type, it.top_value) ||
                operand_truthy(it.second_type, it.second_value);
    end else if (it.operation == OP_LNOT) begin
      r.truth = !operand_truthy(it.top_type, it.top_value);
    end
    return r;
  endfunction

  // Sends one request. The sender works in bursts: when a burst is used up it may drop
  // tvalid for a random gap before the next request.
  task automatic send_request(input logic [3:0] op, input logic [1:0] ta, input logic [31:0] va,
                              input logic [1:0] tb, input logic [31:0] vb);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {vb, tb, va, ta, op};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drops tvalid first so that the last request is not offered again, then waits
  // until every expected result has come back.
  task automatic wait_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Float operand patterns that matter: zeros, infinities, NaNs, subnormals, integers.
  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7f80_0000;
      3: return 32'hff80_0000;
      4: return {$urandom_range(0, 1) == 1, 8'hff, 23'($urandom_range(1, 32'h7f_ffff))};
      5: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
      6: return single_from_int($urandom);
      7: return single_from_int(32'($signed($urandom_range(0, 20)) - 10));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_int();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_value(input logic [1:0] ty);
    if (ty == TY_FLOAT) return pick_float();
    if (ty == TY_INT) return pick_int();
    return $urandom;
  endfunction

  task automatic test_nil_policy();
    for (int op = OP_EQL; op <= OP_LTE; op++) begin
      send_request(4'(op), TY_NIL, 32'h0, TY_NIL, 32'hffff_ffff);
      send_request(4'(op), TY_NIL, 32'h0, TY_INT, 32'h5);
      send_request(4'(op), TY_FLOAT, 32'h0, TY_NIL, 32'h0);
    end
  endtask

  task automatic test_closure_operands();
    send_request(OP_EQL, TY_CLOSURE, 32'h10, TY_CLOSURE, 32'h10);
    send_request(OP_LT, TY_INT, 32'h1, TY_CLOSURE, 32'h0);
    send_request(OP_GTE, TY_CLOSURE, 32'h1, TY_NIL, 32'h0);
  endtask

  task automatic test_numeric_extremes();
    send_request(OP_LT, TY_INT, 32'h8000_0000, TY_INT, 32'h7fff_ffff);
    send_request(OP_GT, TY_INT, 32'hffff_ffff, TY_INT, 32'h0);
    // 2^24+1 rounds down to 2^24 when promoted, so it equals the float 2^24.
    send_request(OP_EQL, TY_INT, 32'h0100_0001, TY_FLOAT, 32'h4b80_0000);
    send_request(OP_EQL, TY_INT, 32'h7fff_ffff, TY_FLOAT, 32'h4f00_0000);
    send_request(OP_EQL, TY_FLOAT, 32'h8000_0000, TY_FLOAT, 32'h0000_0000);
    send_request(OP_NEQL, TY_FLOAT, 32'h7fc0_0000, TY_FLOAT, 32'h7fc0_0000);
    send_request(OP_LTE, TY_FLOAT, 32'h7fc0_0000, TY_INT, 32'h0);
    send_request(OP_GT, TY_FLOAT, 32'h7f80_0000, TY_INT, 32'h7fff_ffff);
  endtask

  task automatic test_truthiness();
    send_request(OP_LAND, TY_FLOAT, 32'h8000_0000, TY_INT, 32'h1);
    send_request(OP_LOR, TY_NIL, 32'hffff_ffff, TY_CLOSURE, 32'h0);
    send_request(OP_LOR, TY_INT, 32'h0, TY_FLOAT, 32'h7fc0_0000);
    send_request(OP_LNOT, TY_NIL, 32'h0, TY_CLOSURE, 32'h0);
    send_request(OP_LNOT, TY_FLOAT, 32'h8000_0000, TY_INT, 32'h0);
  endtask

  task automatic test_unused_codes();
    for (int op = 9; op <= 15; op++) send_request(4'(op), TY_INT, 32'h1, TY_INT, 32'h1);
  endtask

  task automatic test_random_requests(input int count);
    logic [3:0]  op;
    logic [1:0]  ta;
    logic [1:0]  tb;
    logic [31:0] va;
    logic [31:0] vb;
    for (int n = 0; n < count; n++) begin
      // Halfway through, hold back until the pipe has emptied completely.
      if (n == count / 2) wait_until_drained();
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      // Numeric pairs dominate so that the compare paths get most of the traffic.
      if ($urandom_range(0, 3) != 0) begin
        ta = 2'($urandom_range(1, 2));
        tb = 2'($urandom_range(1, 2));
      end else begin
        ta = 2'($urandom);
        tb = 2'($urandom);
      end
      va = pick_value(ta);
      case ($urandom_range(0, 3))
        0: vb = (ta == TY_INT && tb == TY_FLOAT) ? single_from_int(va) : va;
        default: vb = pick_value(tb);
      endcase
      send_request(op, ta, va, tb, vb);
    end
  endtask

  // Receiver back pressure: always ready, random, or a sparse fixed pattern, switched at random.
  initial begin
    m_tready = 1'b0;
    forever begin
      int mode;
      mode = $urandom_range(0, 2);
      for (int c = 0; c < 64; c++) begin
        @(negedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (c % 4) == 0;
        endcase
      end
    end
  end

  // Records accepted requests and checks every result against the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = result_t'({m_tdata[0], m_tdata[2:1]});
        checked_count++;
        if (expected_results.size() == 0) begin
          failures++;
          $display("%0t: result %b arrived with nothing expected", $realtime, m_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.truth !== exp_r.truth || got.fault !== exp_r.fault || m_tdata[7:3] !== 0) begin
            failures++;
            $display("%0t: mismatch, expected truth %b fault %0d, got truth %b fault %0d fill %b",
                     $realtime, exp_r.truth, exp_r.fault, got.truth, got.fault, m_tdata[7:3]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_compare_logic(item_t'({s_tdata[3:0], s_tdata[5:4],
            s_tdata[37:6], s_tdata[39:38], s_tdata[71:40]})));
        accepted_count++;
      end
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("typed_compare_logic_unit_top test failed");
      $finish;
    end
  end

  initial begin
    failures = 0;
    accepted_count = 0;
    checked_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_nil_policy();
    test_closure_operands();
    test_numeric_extremes();
    test_truthiness();
    test_unused_codes();
    test_random_requests(900);
    wait_until_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests and checked %0d results: nil policy, closures, int and float",
             accepted_count, checked_count);
    $display("compares with NaN, zeros and promotion, truthiness and unused codes.");
    if (failures == 0 && expected_results.size() == 0) begin
      $display("typed_compare_logic_unit_top test passed");
    end else begin
      $display("typed_compare_logic_unit_top test failed");
    end
    $finish;
  end

endmodule
